>>> src/tcp_persist_timer_backoff_defines.svh
// Assertion macros shared by the persist timer checker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TCP_PERSIST_TIMER_BACKOFF_DEFINES_SVH
`define TCP_PERSIST_TIMER_BACKOFF_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("persist timer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TPTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("persist timer assertion failed");

`endif

>>> src/tptb_pkg.sv
// Shared types and constants of the TCP persist timer.
// Depends on nothing; used by the request interface and the timer modules.
package tptb_pkg;

	// Default width of a timestamp in ticks.
	localparam int TIME_WIDTH_DEF = 48;

	// Reset value of the interval ceiling and the 31-bit saturation value.
	localparam logic [30:0] LIMIT_RESET = 31'd60000;
	localparam logic [30:0] MAX31       = 31'h7FFF_FFFF;

	// Operation codes carried by each input beat.
	typedef enum logic [1:0] {
		OP_QUERY   = 2'd0,
		OP_UPDATE  = 2'd1,
		OP_PROBE   = 2'd2,
		OP_RESTORE = 2'd3
	} tptb_op_t;

	// Everything of an input beat but the timestamp.
	typedef struct packed {
		tptb_op_t    op;
		logic        peer_win_zero;
		logic        data_pending;
		logic [31:0] rto_ticks;
		logic [31:0] restore_remaining;
		logic [31:0] restore_interval;
		logic        restore_active;
	} tptb_ctl_t;

endpackage

>>> src/tptb_if.sv
// Channel interfaces of the TCP persist timer: request, response and config.
// Depends on tptb_pkg for the default timestamp width.
interface tptb_in_if #(parameter int TIME_WIDTH = tptb_pkg::TIME_WIDTH_DEF);
	logic                    valid;
	logic                    ready;
	logic [1:0]              op;
	logic [TIME_WIDTH-1:0]   now;
	logic                    peer_win_zero;
	logic                    data_pending;
	logic signed [31:0]      rto_ticks;
	logic signed [31:0]      restore_remaining;
	logic signed [31:0]      restore_interval;
	logic                    restore_active;

	modport source (output valid, op, now, peer_win_zero, data_pending, rto_ticks,
		restore_remaining, restore_interval, restore_active, input ready);
	modport sink (input valid, op, now, peer_win_zero, data_pending, rto_ticks,
		restore_remaining, restore_interval, restore_active, output ready);
endinterface

interface tptb_out_if;
	logic        valid;
	logic        ready;
	logic        due;
	logic        accepted;
	logic [30:0] remaining;
	logic [30:0] interval_out;
	logic        active;

	modport source (output valid, due, accepted, remaining, interval_out, active,
		input ready);
	modport sink (input valid, due, accepted, remaining, interval_out, active,
		output ready);
endinterface

interface tptb_cfg_if;
	logic        valid;
	logic        ready;
	logic [30:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> src/tptb_update.sv
// Timer state and its per-beat update: arm, disarm, probe backoff, restore.
// Depends on tptb_pkg for the operation codes and the control struct.
module tptb_update #(
	parameter int TIME_WIDTH = tptb_pkg::TIME_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step_en,
	input  logic [30:0]            lim,
	input  logic [TIME_WIDTH-1:0]  now,
	input  tptb_pkg::tptb_ctl_t    ctl,
	output logic                   accepted,
	output logic                   armed_q,
	output logic [((TIME_WIDTH < 64) ? TIME_WIDTH + 1 : 64)-1:0] deadline_q,
	output logic [30:0]            interval_q
);
	localparam int DL_W = (TIME_WIDTH < 64) ? TIME_WIDTH + 1 : 64;

	logic [DL_W-1:0]    now_ext;
	logic [DL_W-1:0]    deadline_sum;
	logic [30:0]        add_val;
	logic [30:0]        rto_clamped;
	logic [31:0]        doubled;
	logic [30:0]        backoff;
	logic signed [31:0] lim_s;
	logic signed [31:0] rto_s;
	logic signed [31:0] rr_s;
	logic signed [31:0] ri_s;
	logic               probe_ok;
	logic               restore_bad;
	logic               armed_n;
	logic [DL_W-1:0]    deadline_n;
	logic [30:0]        interval_n;

	assign now_ext = DL_W'(now);
	assign lim_s   = $signed({1'b0, lim});
	assign rto_s   = $signed(ctl.rto_ticks);
	assign rr_s    = $signed(ctl.restore_remaining);
	assign ri_s    = $signed(ctl.restore_interval);

	// Arming interval: the RTO clamped to one through the limit.
	always_comb begin
		if (rto_s < 32'sd1) begin
			rto_clamped = 31'd1;
		end else if (rto_s > lim_s) begin
			rto_clamped = lim;
		end else begin
			rto_clamped = rto_s[30:0];
		end
	end

	// Backoff: double the interval, saturating at the limit.
	assign doubled = {interval_q, 1'b0};
	assign backoff = (doubled > {1'b0, lim}) ? lim : doubled[30:0];

	// Probe is taken only once the deadline has been reached.
	assign probe_ok = armed_q && (now_ext >= deadline_q);

	// Checkpoint validation.
	assign restore_bad = rr_s[31] || ri_s[31] || (ri_s > lim_s) ||
		(ctl.restore_active != (ri_s > 32'sd0)) ||
		(!ctl.restore_active && (rr_s != 32'sd0));

	// One shared adder forms the new deadline from the selected offset.
	always_comb begin
		case (ctl.op)
			tptb_pkg::OP_UPDATE:  add_val = rto_clamped;
			tptb_pkg::OP_PROBE:   add_val = backoff;
			tptb_pkg::OP_RESTORE: add_val = rr_s[30:0];
			default:              add_val = '0;
		endcase
	end
	assign deadline_sum = now_ext + DL_W'(add_val);

	// Next state and the accepted flag.
	always_comb begin
		armed_n    = armed_q;
		deadline_n = deadline_q;
		interval_n = interval_q;
		accepted   = 1'b0;
		case (ctl.op)
			tptb_pkg::OP_UPDATE: begin
				if (!ctl.peer_win_zero || !ctl.data_pending) begin
					armed_n    = 1'b0;
					interval_n = '0;
				end else if (!armed_q) begin
					armed_n    = 1'b1;
					interval_n = rto_clamped;
					deadline_n = deadline_sum;
				end
			end
			tptb_pkg::OP_PROBE: begin
				if (probe_ok) begin
					interval_n = backoff;
					deadline_n = deadline_sum;
					accepted   = 1'b1;
				end
			end
			tptb_pkg::OP_RESTORE: begin
				if (!restore_bad) begin
					armed_n    = ctl.restore_active;
					interval_n = ri_s[30:0];
					deadline_n = ctl.restore_active ? deadline_sum : '0;
					accepted   = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// State registers advance once per beat leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q    <= 1'b0;
			deadline_q <= '0;
			interval_q <= '0;
		end else if (step_en) begin
			armed_q    <= armed_n;
			deadline_q <= deadline_n;
			interval_q <= interval_n;
		end
	end
endmodule

>>> src/tptb_report.sv
// Status of the timer after a step: due flag and saturated remaining time.
// Depends on tptb_pkg for the 31-bit saturation value.
module tptb_report #(
	parameter int TIME_WIDTH = tptb_pkg::TIME_WIDTH_DEF
) (
	input  logic                  armed,
	input  logic [((TIME_WIDTH < 64) ? TIME_WIDTH + 1 : 64)-1:0] deadline,
	input  logic [TIME_WIDTH-1:0] now,
	output logic                  due,
	output logic [30:0]           remaining
);
	localparam int DL_W = (TIME_WIDTH < 64) ? TIME_WIDTH + 1 : 64;

	logic [DL_W-1:0] now_ext;
	logic [DL_W-1:0] diff;
	logic            ahead;

	assign now_ext = DL_W'(now);
	assign ahead   = deadline > now_ext;
	assign diff    = deadline - now_ext;

	// Remaining time is zero when idle or at or past the deadline.
	always_comb begin
		if (!armed || !ahead) begin
			remaining = '0;
		end else if (diff > DL_W'(tptb_pkg::MAX31)) begin
			remaining = tptb_pkg::MAX31;
		end else begin
			remaining = diff[30:0];
		end
	end

	assign due = armed && !ahead;
endmodule

>>> src/tcp_persist_timer_backoff.sv
// Top level of the TCP zero-window persist timer with exponential backoff.
// Depends on tptb_pkg, the channel interfaces, tptb_update and tptb_report.
//
// Usage:
//  - req carries one beat per event: operation, timestamp and operands.
//    A beat is taken at a clock edge where req.valid and req.ready are high.
//  - rsp returns exactly one beat per request, in order, with the state
//    after that request: due, accepted, remaining, interval_out, active.
//  - cfg writes the interval ceiling; a zero ceiling acts as one. Write it
//    only while no request is in flight. cfg.ready is always high.
// Timing:
//  - An accepted beat passes the input register, then the state registers
//    and stage two, then the output register, which drives rsp.valid.
//  - Throughput is one beat per cycle; the state update (compares and
//    one deadline add) completes in the cycle a beat leaves the input stage.
//  - When rsp stalls, occupied stages hold and req.ready drops once the
//    pipeline is full; no beat is lost or repeated.
// Reset: arst_n clears the timer (idle, interval zero, deadline zero), sets
//  the ceiling to 60000 ticks and empties the pipeline.
module tcp_persist_timer_backoff #(
	parameter int TIME_WIDTH = tptb_pkg::TIME_WIDTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	tptb_in_if.sink    req,
	tptb_out_if.source rsp,
	tptb_cfg_if.sink   cfg
);
	localparam int DL_W = (TIME_WIDTH < 64) ? TIME_WIDTH + 1 : 64;

	logic [30:0]           limit_q;
	logic [30:0]           eff_lim;
	logic                  v_s1;
	logic                  v_s2;
	logic                  out_valid_q;
	logic                  adv_out;
	logic                  adv2;
	logic                  adv1;
	logic                  step_en;
	tptb_pkg::tptb_ctl_t   ctl_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic [TIME_WIDTH-1:0] now_s2;
	logic                  acc_n;
	logic                  acc_s2;
	logic                  armed;
	logic [DL_W-1:0]       deadline;
	logic [30:0]           interval;
	logic                  due_n;
	logic [30:0]           rem_n;
	logic                  due_q;
	logic                  acc_q;
	logic [30:0]           rem_q;
	logic [30:0]           interval_q;
	logic                  active_q;

	// Interval ceiling register.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= tptb_pkg::LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.data;
		end
	end
	assign eff_lim = (limit_q == '0) ? 31'd1 : limit_q;

	// Pipeline flow: each stage moves when the one after it can take a beat.
	assign adv_out   = !out_valid_q || rsp.ready;
	assign adv2      = !v_s2 || adv_out;
	assign adv1      = !v_s1 || adv2;
	assign req.ready = adv1;
	assign step_en   = v_s1 && adv2;

	// Input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv1) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && req.valid) begin
			ctl_s1.op                <= tptb_pkg::tptb_op_t'(req.op);
			ctl_s1.peer_win_zero     <= req.peer_win_zero;
			ctl_s1.data_pending      <= req.data_pending;
			ctl_s1.rto_ticks         <= req.rto_ticks;
			ctl_s1.restore_remaining <= req.restore_remaining;
			ctl_s1.restore_interval  <= req.restore_interval;
			ctl_s1.restore_active    <= req.restore_active;
			now_s1                   <= req.now;
		end
	end

	// State update; its registers hold the state after the beat in stage two.
	tptb_update #(.TIME_WIDTH(TIME_WIDTH)) u_update (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_en    (step_en),
		.lim        (eff_lim),
		.now        (now_s1),
		.ctl        (ctl_s1),
		.accepted   (acc_n),
		.armed_q    (armed),
		.deadline_q (deadline),
		.interval_q (interval)
	);

	// Stage two carries the timestamp and accepted flag beside the state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			now_s2 <= now_s1;
			acc_s2 <= acc_n;
		end
	end

	tptb_report #(.TIME_WIDTH(TIME_WIDTH)) u_report (
		.armed     (armed),
		.deadline  (deadline),
		.now       (now_s2),
		.due       (due_n),
		.remaining (rem_n)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			due_q      <= due_n;
			acc_q      <= acc_s2;
			rem_q      <= rem_n;
			interval_q <= interval;
			active_q   <= armed;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.due          = due_q;
	assign rsp.accepted     = acc_q;
	assign rsp.remaining    = rem_q;
	assign rsp.interval_out = interval_q;
	assign rsp.active       = active_q;
endmodule

>>> src/tptb_checker.sv
// Port-level checks of the persist timer response channel, bound to the top.
// Depends on tcp_persist_timer_backoff_defines.svh for the assertion macros.
`include "tcp_persist_timer_backoff_defines.svh"

module tptb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_due,
	input logic [30:0] rsp_remaining,
	input logic [30:0] rsp_interval_out,
	input logic        rsp_active
);
	// A stalled response beat stays put.
	`TPTB_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_remaining))

	// A due timer must be armed.
	`TPTB_ASSERT_IMP(a_due_active, clk, arst_n, rsp_valid && rsp_due, rsp_active)

	// A due timer has no time left.
	`TPTB_ASSERT_IMP(a_due_zero, clk, arst_n, rsp_valid && rsp_due, rsp_remaining == 31'd0)

	// An armed timer always has a nonzero interval, an idle one a zero interval.
	`TPTB_ASSERT_IMP(a_active_interval, clk, arst_n, rsp_valid, rsp_active == (rsp_interval_out != 31'd0))
endmodule

bind tcp_persist_timer_backoff tptb_checker u_tptb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_due          (rsp.due),
	.rsp_remaining    (rsp.remaining),
	.rsp_interval_out (rsp.interval_out),
	.rsp_active       (rsp.active)
);
